[rtl/key_autorepeat_double_press_core_defines.svh]
// ----------------------------------------------------------------------------
// Key auto-repeat core: assertion macros
// Shared concurrent assertion shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef KEY_AUTOREPEAT_DOUBLE_PRESS_CORE_DEFINES_SVH
`define KEY_AUTOREPEAT_DOUBLE_PRESS_CORE_DEFINES_SVH

// Assertion that is switched off while reset is asserted (active low)
`define KAD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is also checked across reset
`define KAD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/kad_pkg.sv]
// ----------------------------------------------------------------------------
// Key auto-repeat package
// Payload structs, register indexes and reset constants.
// ----------------------------------------------------------------------------
`default_nettype none

package kad_pkg;

    localparam int CFG_W     = 32;  // widest configuration register
    localparam int CFG_IDX_W = 2;
    localparam int TICK_W    = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REPEAT_ENABLE   = 2'd0,
        CFG_REPEAT_DELAY    = 2'd1,
        CFG_REPEAT_INTERVAL = 2'd2,
        CFG_DOUBLE_WINDOW   = 2'd3
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] RST_REPEAT_DELAY    = 32'd500000;
    localparam logic [CFG_W-1:0] RST_REPEAT_INTERVAL = 32'd50000;
    localparam logic [CFG_W-1:0] RST_DOUBLE_WINDOW   = 32'd300000;

    typedef struct packed {
        logic              key_down;
        logic [TICK_W-1:0] now_ticks;
    } t_kad_in;

    typedef struct packed {
        logic pressed;
        logic double_pressed;
    } t_kad_out;

    // Single-bit tracking state of the key
    typedef struct packed {
        logic was_down;
        logic held;
        logic await_first;
        logic tap_valid;
        logic pressed;
        logic dbl;
    } t_kad_flags;

    localparam t_kad_flags KAD_FLAGS_RST = '{
        was_down:    1'b0,
        held:        1'b0,
        await_first: 1'b1,
        tap_valid:   1'b0,
        pressed:     1'b0,
        dbl:         1'b0
    };

endpackage

`default_nettype wire

[rtl/kad_update.sv]
// ----------------------------------------------------------------------------
// Key auto-repeat next-state logic
// One poll: repeat timing, release, double-press detection or pass-through.
// ----------------------------------------------------------------------------
`default_nettype none

module kad_update #(
    parameter int TIME_BITS = 32
) (
    input  kad_pkg::t_kad_in                i_in,
    input  kad_pkg::t_kad_flags             i_flags,
    input  logic [TIME_BITS-1:0]            i_last_pulse,
    input  logic [TIME_BITS-1:0]            i_tap_time,
    input  logic                            i_repeat_enable,
    input  logic [kad_pkg::CFG_W-1:0]       i_repeat_delay,
    input  logic [kad_pkg::CFG_W-1:0]       i_repeat_interval,
    input  logic [kad_pkg::CFG_W-1:0]       i_double_window,
    output kad_pkg::t_kad_flags             o_flags,
    output logic [TIME_BITS-1:0]            o_last_pulse,
    output logic [TIME_BITS-1:0]            o_tap_time
);
    import kad_pkg::*;

    // compare width covers both the time base and the 32-bit limits
    localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

    logic [TIME_BITS-1:0] w_now;
    logic [TIME_BITS-1:0] w_since_pulse;
    logic [TIME_BITS-1:0] w_since_tap;
    logic [CFG_W-1:0]     w_limit;
    logic                 w_repeat_due;
    logic                 w_in_window;
    logic                 w_rise;

    assign w_now         = TIME_BITS'(i_in.now_ticks);
    assign w_since_pulse = w_now - i_last_pulse;  // wraps mod 2^TIME_BITS
    assign w_since_tap   = w_now - i_tap_time;
    assign w_limit       = i_flags.await_first ? i_repeat_delay : i_repeat_interval;
    assign w_repeat_due  = CMP_W'(w_since_pulse) >= CMP_W'(w_limit);
    assign w_in_window   = CMP_W'(w_since_tap) <= CMP_W'(i_double_window);
    assign w_rise        = i_in.key_down && !i_flags.was_down;

    always_comb begin
        o_flags      = i_flags;
        o_last_pulse = i_last_pulse;
        o_tap_time   = i_tap_time;

        if (!i_repeat_enable) begin
            // pass-through: only the level follows the key
            o_flags.pressed = i_in.key_down;
        end else begin
            if (i_in.key_down) begin
                if (w_rise) begin
                    o_flags.pressed     = 1'b1;
                    o_flags.held        = 1'b1;
                    o_flags.await_first = 1'b1;
                    o_last_pulse        = w_now;
                end else if (i_flags.held) begin
                    if (w_repeat_due) begin
                        o_flags.pressed     = 1'b1;
                        o_flags.await_first = 1'b0;
                        o_last_pulse        = w_now;
                    end else begin
                        o_flags.pressed = 1'b0;
                    end
                end
                // down but not held: pressed keeps its value
            end else begin
                o_flags.pressed     = 1'b0;
                o_flags.held        = 1'b0;
                o_flags.await_first = 1'b1;
                o_last_pulse        = '0;
            end

            o_flags.dbl = 1'b0;
            if (w_rise) begin
                if (i_flags.tap_valid && w_in_window) begin
                    o_flags.dbl       = 1'b1;
                    o_flags.tap_valid = 1'b0;
                end else begin
                    o_tap_time        = w_now;
                    o_flags.tap_valid = 1'b1;
                end
            end

            o_flags.was_down = i_in.key_down;
        end
    end

endmodule

`default_nettype wire

[rtl/key_autorepeat_double_press_core.sv]
// ----------------------------------------------------------------------------
// Key auto-repeat with double-press detection
// Typematic repeat and double-press flag for one polled key.
// ----------------------------------------------------------------------------
// Result: the result of a poll is registered and valid in the cycle after the poll's transaction.
// Throughput: one poll per cycle; the configuration, key state and result
//   registers are the only storage, and a poll is taken whenever the result
//   slot is free or drained in the same cycle.
// Reset (synchronous, active low): registers return to their documented
//   defaults, key state is cleared and no result is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module key_autorepeat_double_press_core #(
    parameter int TIME_BITS = 32   // width of the wrapping time base, 16..64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [kad_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [kad_pkg::CFG_W-1:0]       i_cfg_wdata,
    // poll channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  kad_pkg::t_kad_in                i_in,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output kad_pkg::t_kad_out               o_out
);
    import kad_pkg::*;

    // configuration registers
    logic             r_repeat_enable;
    logic [CFG_W-1:0] r_repeat_delay;
    logic [CFG_W-1:0] r_repeat_interval;
    logic [CFG_W-1:0] r_double_window;

    // key state; r_flags.pressed/dbl double as the result register
    t_kad_flags           r_flags;
    t_kad_flags           n_flags;
    logic [TIME_BITS-1:0] r_last_pulse;
    logic [TIME_BITS-1:0] n_last_pulse;
    logic [TIME_BITS-1:0] r_tap_time;
    logic [TIME_BITS-1:0] n_tap_time;
    logic                 r_out_valid;

    logic w_in_fire;

    // The result slot frees up in the same cycle it is drained, so a new
    // poll can follow every cycle. While a result waits, the state that
    // drives it must hold, hence no poll is taken then.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_in_fire  = i_in_valid && o_in_ready;

    // ---- configuration ---------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_enable   <= 1'b0;
            r_repeat_delay    <= RST_REPEAT_DELAY;
            r_repeat_interval <= RST_REPEAT_INTERVAL;
            r_double_window   <= RST_DOUBLE_WINDOW;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_REPEAT_ENABLE:   r_repeat_enable   <= i_cfg_wdata[0];
                CFG_REPEAT_DELAY:    r_repeat_delay    <= i_cfg_wdata;
                CFG_REPEAT_INTERVAL: r_repeat_interval <= i_cfg_wdata;
                CFG_DOUBLE_WINDOW:   r_double_window   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---- per-poll update -------------------------------------------------
    kad_update #(
        .TIME_BITS (TIME_BITS)
    ) u_update (
        .i_in              (i_in),
        .i_flags           (r_flags),
        .i_last_pulse      (r_last_pulse),
        .i_tap_time        (r_tap_time),
        .i_repeat_enable   (r_repeat_enable),
        .i_repeat_delay    (r_repeat_delay),
        .i_repeat_interval (r_repeat_interval),
        .i_double_window   (r_double_window),
        .o_flags           (n_flags),
        .o_last_pulse      (n_last_pulse),
        .o_tap_time        (n_tap_time)
    );

    // State commits only on a poll transaction; timestamps start at zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags      <= KAD_FLAGS_RST;
            r_last_pulse <= '0;
            r_tap_time   <= '0;
        end else if (w_in_fire) begin
            r_flags      <= n_flags;
            r_last_pulse <= n_last_pulse;
            r_tap_time   <= n_tap_time;
        end
    end

    // ---- result handshake ------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_out.pressed        = r_flags.pressed;
    assign o_out.double_pressed = r_flags.dbl;

endmodule

`default_nettype wire

[rtl/kad_checker.sv]
// ----------------------------------------------------------------------------
// Key auto-repeat port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
`default_nettype none

`include "key_autorepeat_double_press_core_defines.svh"

module kad_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            o_in_ready,
    input  kad_pkg::t_kad_in                i_in,
    input  logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  kad_pkg::t_kad_out               o_out
);

    // a stalled result stays put
    `KAD_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out), "result changed while stalled")

    // a waiting poll keeps valid and its payload
    `KAD_ASSERT(a_in_hold, i_clk, i_rst_n, i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in), "poll changed while waiting")

    // every accepted poll yields a result on the next cycle
    `KAD_ASSERT(a_poll_result, i_clk, i_rst_n, i_in_valid && o_in_ready |=> o_out_valid, "poll transaction produced no result")

    // an empty result slot never blocks a poll
    `KAD_ASSERT(a_ready_empty, i_clk, i_rst_n, !o_out_valid |-> o_in_ready, "input stalled with empty result slot")

    // reset leaves no result pending
    `KAD_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind key_autorepeat_double_press_core kad_checker u_kad_checker (.*);

`default_nettype wire
